[src/stlcg_pkg.sv]
// Shared constants, types and codes for the shuffled triple-LCG uniform generator.
// No dependencies; every other file in src/ refers to this package by scoped name.
`default_nettype none

package stlcg_pkg;

    localparam int TABLE_SIZE = 97;
    localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int PART_W     = 18;
    localparam int WORD_W     = 32;
    localparam int ENTRY_W    = 2 * PART_W;
    localparam int N_GEN      = 3;

    localparam int GEN_A = 0;
    localparam int GEN_B = 1;
    localparam int GEN_C = 2;

    localparam int MUL_W = 13;
    localparam int INC_W = 16;

    localparam logic [PART_W-1:0] MOD_A = 18'd259200;
    localparam logic [PART_W-1:0] MOD_B = 18'd134456;
    localparam logic [PART_W-1:0] MOD_C = 18'd243000;

    localparam logic [MUL_W-1:0] LCG_MUL [N_GEN] = '{13'd7141, 13'd8121, 13'd4561};
    localparam logic [INC_W-1:0] LCG_INC [N_GEN] = '{16'd54773, 16'd28411, 16'd51349};
    localparam logic [PART_W-1:0] LCG_MOD [N_GEN] = '{MOD_A, MOD_B, MOD_C};

    // Exact floor(p / m) for p < 2^32, m < 2^18: q = (p * ceil(2^50 / m)) >> 50
    localparam int RCP_SHIFT = 50;
    localparam int RCP_W     = 33;
    localparam int QUO_W     = 15;
    localparam int PROD_W    = WORD_W + RCP_W;
    localparam logic [RCP_W-1:0] LCG_RCP [N_GEN] = '{
        33'(((66'd1 << RCP_SHIFT) + 66'd259199) / 66'd259200),
        33'(((66'd1 << RCP_SHIFT) + 66'd134455) / 66'd134456),
        33'(((66'd1 << RCP_SHIFT) + 66'd242999) / 66'd243000)
    };

    // Generator operation codes
    localparam logic LCG_LOAD = 1'b0;  // lane A: load_val mod MOD_A
    localparam logic LCG_ADV  = 1'b1;  // all lanes: one LCG step

    localparam logic signed [WORD_W-1:0] SEED_MAX = 32'sd54773;

    // Slot pick: floor(TABLE_SIZE * c / MOD_C) as (c * K) >> SLOT_SHIFT, exact for c < 2^18
    localparam int    SLOT_SHIFT = 36;
    localparam longint SLOT_MUL_V =
        ((longint'(TABLE_SIZE) << SLOT_SHIFT) + longint'(MOD_C) - 1) / longint'(MOD_C);
    localparam int    SLOT_MUL_W  = $clog2(SLOT_MUL_V + 1);
    localparam int    SLOT_PROD_W = PART_W + SLOT_MUL_W;
    localparam logic [SLOT_MUL_W-1:0] SLOT_MUL = SLOT_MUL_W'(SLOT_MUL_V);

    // Fraction: floor(n * 2^32 / (MOD_A * MOD_B)), restoring divide
    localparam int NUM_W = 36;
    localparam logic [NUM_W-1:0] FRAC_DEN = 36'd34850995200;
    localparam int DIV_BITS   = 4;
    localparam int DIV_STEPS  = WORD_W / DIV_BITS;
    localparam int DIV_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    typedef logic [PART_W-1:0]  part_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [ENTRY_W-1:0] entry_t;

    typedef struct packed {
        logic start;
        logic mode;
    } lcg_ctl_t;

endpackage

`default_nettype wire

[src/stlcg_if.sv]
// Valid/ready channel interfaces for draw requests and result words.
// Depends on stlcg_pkg for payload types.
`default_nettype none

interface stlcg_in_if;
    logic valid;
    logic ready;
    logic reseed;

    modport source (output valid, output reseed, input ready);
    modport sink (input valid, input reseed, output ready);
endinterface

interface stlcg_out_if;
    logic                 valid;
    logic                 ready;
    stlcg_pkg::word_t     value_q32;
    stlcg_pkg::part_t     coarse_part;
    stlcg_pkg::part_t     fine_part;

    modport source (output valid, output value_q32, output coarse_part, output fine_part,
                    input ready);
    modport sink (input valid, input value_q32, input coarse_part, input fine_part,
                  output ready);
endinterface

`default_nettype wire

[src/shuffled_triple_lcg_uniform_top.sv]
// A draw runs one generator step in the 3-stage LCG unit, one table read, and a
// restoring divide that yields 4 fraction bits at a time; a new draw is accepted only
// in idle, once the previous word has been loaded for output. A draw that seeds first
// adds 100 generator steps, 97 of which fill one table slot each.
// Reset clears seed, generators and the seeded flag, so the first draw always seeds;
// the shuffle table has no reset.
`default_nettype none

module shuffled_triple_lcg_uniform_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic signed [31:0] cfg_wdata,
    stlcg_in_if.sink                in_ch,
    stlcg_out_if.source             out_ch
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SEED0 = 4'd1;
    localparam logic [3:0] S_SEED1 = 4'd2;
    localparam logic [3:0] S_SEED2 = 4'd3;
    localparam logic [3:0] S_FILL  = 4'd4;
    localparam logic [3:0] S_DRAW  = 4'd5;
    localparam logic [3:0] S_READ  = 4'd6;
    localparam logic [3:0] S_WRITE = 4'd7;
    localparam logic [3:0] S_DIV   = 4'd8;
    localparam logic [3:0] S_HOLD  = 4'd9;

    logic [3:0] state_reg, state_next;
    logic signed [31:0] seed_reg;
    logic seeded_reg, seeded_next;
    stlcg_pkg::part_t gen_a_reg, gen_a_next;
    stlcg_pkg::part_t gen_b_reg, gen_b_next;
    stlcg_pkg::part_t gen_c_reg, gen_c_next;
    logic [stlcg_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic [stlcg_pkg::IDX_W-1:0] slot_reg, slot_next;
    stlcg_pkg::lcg_ctl_t lcg_ctl_reg, lcg_ctl_next;

    stlcg_pkg::entry_t mem [stlcg_pkg::TABLE_SIZE];
    stlcg_pkg::entry_t rd_data_reg;
    logic mem_we;
    logic [stlcg_pkg::IDX_W-1:0] mem_waddr;
    stlcg_pkg::entry_t mem_wdata;

    logic seed_sat;
    stlcg_pkg::word_t seed_start;
    stlcg_pkg::part_t [stlcg_pkg::N_GEN-1:0] lcg_x;
    stlcg_pkg::part_t [stlcg_pkg::N_GEN-1:0] lcg_y;
    logic lcg_done;
    stlcg_pkg::part_t y_a_mod_b;
    stlcg_pkg::part_t y_a_mod_c;
    logic [stlcg_pkg::SLOT_PROD_W-1:0] slot_prod;

    logic div_start;
    logic div_done;
    stlcg_pkg::word_t div_q;

    logic out_load;
    logic out_valid_reg;
    stlcg_pkg::word_t out_q_reg;
    stlcg_pkg::part_t out_a_reg;
    stlcg_pkg::part_t out_b_reg;

    logic in_accept;

    assign in_accept = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == S_IDLE);

    // seed above SEED_MAX clamps; otherwise SEED_MAX - seed fits 32 bits unsigned
    assign seed_sat   = (seed_reg > stlcg_pkg::SEED_MAX);
    assign seed_start = seed_sat ? '0 : stlcg_pkg::word_t'(stlcg_pkg::SEED_MAX - seed_reg);

    assign lcg_x[stlcg_pkg::GEN_A] = gen_a_reg;
    assign lcg_x[stlcg_pkg::GEN_B] = gen_b_reg;
    assign lcg_x[stlcg_pkg::GEN_C] = gen_c_reg;

    // lane A output is below MOD_A, under twice MOD_B and MOD_C
    assign y_a_mod_b = (lcg_y[stlcg_pkg::GEN_A] >= stlcg_pkg::MOD_B)
                     ? lcg_y[stlcg_pkg::GEN_A] - stlcg_pkg::MOD_B : lcg_y[stlcg_pkg::GEN_A];
    assign y_a_mod_c = (lcg_y[stlcg_pkg::GEN_A] >= stlcg_pkg::MOD_C)
                     ? lcg_y[stlcg_pkg::GEN_A] - stlcg_pkg::MOD_C : lcg_y[stlcg_pkg::GEN_A];

    assign slot_prod = stlcg_pkg::SLOT_PROD_W'(lcg_y[stlcg_pkg::GEN_C])
                     * stlcg_pkg::SLOT_PROD_W'(stlcg_pkg::SLOT_MUL);

    stlcg_lcg u_lcg (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (lcg_ctl_reg),
        .load_val (seed_start),
        .x        (lcg_x),
        .done     (lcg_done),
        .y        (lcg_y)
    );

    stlcg_q32 u_q32 (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .a     (rd_data_reg[stlcg_pkg::ENTRY_W-1:stlcg_pkg::PART_W]),
        .b     (rd_data_reg[stlcg_pkg::PART_W-1:0]),
        .done  (div_done),
        .q     (div_q)
    );

    always_comb
    begin
        state_next   = state_reg;
        seeded_next  = seeded_reg;
        gen_a_next   = gen_a_reg;
        gen_b_next   = gen_b_reg;
        gen_c_next   = gen_c_reg;
        idx_next     = idx_reg;
        slot_next    = slot_reg;
        lcg_ctl_next = '{start: 1'b0, mode: stlcg_pkg::LCG_ADV};
        mem_we       = 1'b0;
        mem_waddr    = slot_reg;
        mem_wdata    = {gen_a_reg, gen_b_reg};
        div_start    = 1'b0;
        out_load     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    lcg_ctl_next.start = 1'b1;
                    if (in_ch.reseed || !seeded_reg)
                    begin
                        lcg_ctl_next.mode = stlcg_pkg::LCG_LOAD;
                        state_next        = S_SEED0;
                    end
                    else
                    begin
                        state_next = S_DRAW;
                    end
                end
            end
            S_SEED0:
            begin
                if (lcg_done)
                begin
                    gen_a_next         = lcg_y[stlcg_pkg::GEN_A];
                    lcg_ctl_next.start = 1'b1;
                    state_next         = S_SEED1;
                end
            end
            S_SEED1:
            begin
                if (lcg_done)
                begin
                    gen_a_next         = lcg_y[stlcg_pkg::GEN_A];
                    gen_b_next         = y_a_mod_b;
                    lcg_ctl_next.start = 1'b1;
                    state_next         = S_SEED2;
                end
            end
            S_SEED2:
            begin
                if (lcg_done)
                begin
                    gen_a_next         = lcg_y[stlcg_pkg::GEN_A];
                    gen_c_next         = y_a_mod_c;
                    idx_next           = '0;
                    lcg_ctl_next.start = 1'b1;
                    state_next         = S_FILL;
                end
            end
            S_FILL:
            begin
                // lane C result is discarded while filling
                if (lcg_done)
                begin
                    gen_a_next         = lcg_y[stlcg_pkg::GEN_A];
                    gen_b_next         = lcg_y[stlcg_pkg::GEN_B];
                    mem_we             = 1'b1;
                    mem_waddr          = idx_reg;
                    mem_wdata          = {lcg_y[stlcg_pkg::GEN_A], lcg_y[stlcg_pkg::GEN_B]};
                    lcg_ctl_next.start = 1'b1;
                    if (idx_reg == stlcg_pkg::IDX_W'(stlcg_pkg::TABLE_SIZE - 1))
                    begin
                        seeded_next = 1'b1;
                        state_next  = S_DRAW;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            S_DRAW:
            begin
                if (lcg_done)
                begin
                    gen_a_next = lcg_y[stlcg_pkg::GEN_A];
                    gen_b_next = lcg_y[stlcg_pkg::GEN_B];
                    gen_c_next = lcg_y[stlcg_pkg::GEN_C];
                    slot_next  = slot_prod[stlcg_pkg::SLOT_SHIFT +: stlcg_pkg::IDX_W];
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                // old entry already captured in rd_data_reg
                mem_we     = 1'b1;
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= '0;
            seeded_reg    <= 1'b0;
            gen_a_reg     <= '0;
            gen_b_reg     <= '0;
            gen_c_reg     <= '0;
            idx_reg       <= '0;
            lcg_ctl_reg   <= '{start: 1'b0, mode: stlcg_pkg::LCG_ADV};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            seeded_reg  <= seeded_next;
            gen_a_reg   <= gen_a_next;
            gen_b_reg   <= gen_b_next;
            gen_c_reg   <= gen_c_next;
            idx_reg     <= idx_next;
            lcg_ctl_reg <= lcg_ctl_next;
            if (cfg_we)
            begin
                seed_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        if (out_load)
        begin
            out_q_reg <= div_q;
            out_a_reg <= rd_data_reg[stlcg_pkg::ENTRY_W-1:stlcg_pkg::PART_W];
            out_b_reg <= rd_data_reg[stlcg_pkg::PART_W-1:0];
        end
    end

    // shuffle table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == S_READ)
        begin
            rd_data_reg <= mem[slot_reg];
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.value_q32   = out_q_reg;
    assign out_ch.coarse_part = out_a_reg;
    assign out_ch.fine_part   = out_b_reg;

`ifndef SYNTHESIS
    a_lcg_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        lcg_done |-> (state_reg == S_SEED0 || state_reg == S_SEED1 || state_reg == S_SEED2
                      || state_reg == S_FILL || state_reg == S_DRAW))
        else $error("generator result arrived with no step pending");

    a_div_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV))
        else $error("fraction result arrived outside divide wait");

    a_fill_sets_seeded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL && lcg_done
         && idx_reg == stlcg_pkg::IDX_W'(stlcg_pkg::TABLE_SIZE - 1)) |=> seeded_reg)
        else $error("table fill finished without marking seeded");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (slot_reg <= stlcg_pkg::IDX_W'(stlcg_pkg::TABLE_SIZE - 1)))
        else $error("slot index beyond table");
`endif

endmodule

`default_nettype wire

[src/stlcg_lcg.sv]
// Three-lane LCG step unit: multiply-add, reciprocal quotient, remainder (3 stages).
// Depends on stlcg_pkg.
`default_nettype none

module stlcg_lcg (
    input  wire logic                                          clk,
    input  wire logic                                          rst_n,
    input  wire stlcg_pkg::lcg_ctl_t                           ctl,
    input  wire stlcg_pkg::word_t                              load_val,
    input  wire stlcg_pkg::part_t [stlcg_pkg::N_GEN-1:0]       x,
    output logic                                               done,
    output stlcg_pkg::part_t [stlcg_pkg::N_GEN-1:0]            y
);

    stlcg_pkg::word_t  p1_next [stlcg_pkg::N_GEN];
    stlcg_pkg::word_t  p1_reg  [stlcg_pkg::N_GEN];
    logic [stlcg_pkg::PROD_W-1:0] prod2 [stlcg_pkg::N_GEN];
    logic [stlcg_pkg::QUO_W-1:0]  q2_reg [stlcg_pkg::N_GEN];
    stlcg_pkg::word_t  p2_reg  [stlcg_pkg::N_GEN];
    stlcg_pkg::part_t [stlcg_pkg::N_GEN-1:0] y_next;
    stlcg_pkg::part_t [stlcg_pkg::N_GEN-1:0] y_reg;
    logic [2:0] v_reg;

    always_comb
    begin
        for (int l = 0; l < stlcg_pkg::N_GEN; l++)
        begin
            if (ctl.mode == stlcg_pkg::LCG_ADV)
            begin
                p1_next[l] = stlcg_pkg::word_t'(x[l]) * stlcg_pkg::word_t'(stlcg_pkg::LCG_MUL[l])
                           + stlcg_pkg::word_t'(stlcg_pkg::LCG_INC[l]);
            end
            else if (l == stlcg_pkg::GEN_A)
            begin
                p1_next[l] = load_val;
            end
            else
            begin
                p1_next[l] = stlcg_pkg::word_t'(x[l]);
            end
            prod2[l] = stlcg_pkg::PROD_W'(p1_reg[l])
                     * stlcg_pkg::PROD_W'(stlcg_pkg::LCG_RCP[l]);
            y_next[l] = stlcg_pkg::PART_W'(p2_reg[l]
                      - stlcg_pkg::word_t'(q2_reg[l]) * stlcg_pkg::word_t'(stlcg_pkg::LCG_MOD[l]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[1:0], ctl.start};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < stlcg_pkg::N_GEN; l++)
        begin
            p1_reg[l] <= p1_next[l];
            q2_reg[l] <= prod2[l][stlcg_pkg::RCP_SHIFT +: stlcg_pkg::QUO_W];
            p2_reg[l] <= p1_reg[l];
        end
        y_reg <= y_next;
    end

    assign done = v_reg[2];
    assign y    = y_reg;

endmodule

`default_nettype wire

[src/stlcg_q32.sv]
// Fraction unit: n = a*MOD_B + b, then floor(n * 2^32 / (MOD_A*MOD_B)),
// four quotient bits per cycle. Depends on stlcg_pkg.
`default_nettype none

module stlcg_q32 (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire stlcg_pkg::part_t  a,
    input  wire stlcg_pkg::part_t  b,
    output logic                   done,
    output stlcg_pkg::word_t       q
);

    logic [stlcg_pkg::NUM_W-1:0]     num;
    logic [stlcg_pkg::NUM_W-1:0]     rem_reg;
    logic [stlcg_pkg::NUM_W-1:0]     rem_next;
    logic [stlcg_pkg::NUM_W:0]       trial;
    logic [stlcg_pkg::DIV_BITS-1:0]  bits;
    stlcg_pkg::word_t                quo_reg;
    logic [stlcg_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                            run_reg;
    logic                            done_reg;

    assign num = stlcg_pkg::NUM_W'(a) * stlcg_pkg::NUM_W'(stlcg_pkg::MOD_B)
               + stlcg_pkg::NUM_W'(b);

    // remainder stays below the divisor, so the doubled value fits one extra bit
    always_comb
    begin
        rem_next = rem_reg;
        bits     = '0;
        trial    = '0;
        for (int k = 0; k < stlcg_pkg::DIV_BITS; k++)
        begin
            trial = {rem_next, 1'b0};
            if (trial >= {1'b0, stlcg_pkg::FRAC_DEN})
            begin
                bits[stlcg_pkg::DIV_BITS-1-k] = 1'b1;
                trial = trial - {1'b0, stlcg_pkg::FRAC_DEN};
            end
            rem_next = trial[stlcg_pkg::NUM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == stlcg_pkg::DIV_CNT_W'(stlcg_pkg::DIV_STEPS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[stlcg_pkg::WORD_W-stlcg_pkg::DIV_BITS-1:0], bits};
        end
    end

    assign done = done_reg;
    assign q    = quo_reg;

endmodule

`default_nettype wire
